// ----- rtl/core/eed_pkg.sv -----
// Shared types and constants for the energy endpoint detector.
// Holds field widths, register indexes, stop codes and the configuration struct.
// Depends on nothing; every other file of the block imports it.
package eed_pkg;

   // Fixed field widths.
   localparam int ENERGY_W   = 43;
   localparam int COUNT_W    = 16;
   localparam int BASE_W     = 21;
   localparam int START_W    = 20;
   localparam int CFG_LEN_W  = 13;
   localparam int CFG_CAP_W  = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 43;

   // Defaults for the top-level parameters.
   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int DEF_MAX_FRAME_LEN = 4096;
   localparam int DEF_MAX_CAPACITY  = 1048576;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEECH_FRAMES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HANGOVER_FRAMES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_SAMPLES  = 3'd4;

   // Reset values of the registers.
   localparam logic [CFG_LEN_W-1:0] RST_FRAME_LENGTH      = 13'd512;
   localparam logic [ENERGY_W-1:0]  RST_ENERGY_THRESHOLD  = 43'd1000000;
   localparam logic [COUNT_W-1:0]   RST_MIN_SPEECH_FRAMES = 16'd5;
   localparam logic [COUNT_W-1:0]   RST_HANGOVER_FRAMES   = 16'd10;
   localparam logic [CFG_CAP_W-1:0] RST_CAPACITY_SAMPLES  = 21'd80000;

   typedef enum logic [1:0] {
      STOP_RUN      = 2'd0,
      STOP_ENDPOINT = 2'd1,
      STOP_FULL     = 2'd2
   } stop_code_type;

   typedef struct packed {
      logic [CFG_LEN_W-1:0] frame_length;
      logic [ENERGY_W-1:0]  energy_threshold;
      logic [COUNT_W-1:0]   min_speech_frames;
      logic [COUNT_W-1:0]   hangover_frames;
      logic [CFG_CAP_W-1:0] capacity_samples;
   } eed_cfg_type;

endpackage

// ----- rtl/core/eed_csr.sv -----
// Configuration register file of the energy endpoint detector.
// Decodes writes by index and presents the registers as one struct.
// Depends on eed_pkg.
module eed_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [eed_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [eed_pkg::CSR_DATA_W-1:0]  csr_data,
   output eed_pkg::eed_cfg_type            cfg
);
   import eed_pkg::*;

   eed_cfg_type cfg_ff;
   eed_cfg_type cfg_in;

   // Writes are refused while reset is high, since reset reloads the defaults.
   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_LENGTH:      cfg_in.frame_length      = csr_data[CFG_LEN_W-1:0];
            CSR_ENERGY_THRESHOLD:  cfg_in.energy_threshold  = csr_data[ENERGY_W-1:0];
            CSR_MIN_SPEECH_FRAMES: cfg_in.min_speech_frames = csr_data[COUNT_W-1:0];
            CSR_HANGOVER_FRAMES:   cfg_in.hangover_frames   = csr_data[COUNT_W-1:0];
            CSR_CAPACITY_SAMPLES:  cfg_in.capacity_samples  = csr_data[CFG_CAP_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length      <= RST_FRAME_LENGTH;
         cfg_ff.energy_threshold  <= RST_ENERGY_THRESHOLD;
         cfg_ff.min_speech_frames <= RST_MIN_SPEECH_FRAMES;
         cfg_ff.hangover_frames   <= RST_HANGOVER_FRAMES;
         cfg_ff.capacity_samples  <= RST_CAPACITY_SAMPLES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/energy_endpoint_detector_unit.sv -----
// Energy endpoint detector: one result per request. An accepted request is registered in stage
// one, then loads the result register, which raises rsp_valid; stage one waits while it is untaken.
// Throughput is one request per cycle while results are taken; the sample square is registered
// in the first stage and the frame decision and counter update are done in the second stage.
// Synchronous active-high reset clears the pipeline, all detector state and loads register
// defaults; ready is low during reset, and requests are taken in the cycle after reset.
module energy_endpoint_detector_unit #(
   parameter int SAMPLE_WIDTH  = eed_pkg::DEF_SAMPLE_WIDTH,
   parameter int MAX_FRAME_LEN = eed_pkg::DEF_MAX_FRAME_LEN,
   parameter int MAX_CAPACITY  = eed_pkg::DEF_MAX_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_frame_done,
   output logic                                rsp_frame_speech,
   output logic                                rsp_speech_found,
   output logic [1:0]                          rsp_status,
   output logic [eed_pkg::START_W-1:0]         rsp_speech_start,
   output logic [eed_pkg::BASE_W-1:0]          rsp_samples_taken,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [eed_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [eed_pkg::CSR_DATA_W-1:0]      csr_data
);
   import eed_pkg::*;

   // Width of the in-frame position: it holds up to the largest frame length.
   localparam int LEN_W     = $clog2(MAX_FRAME_LEN + 1);
   localparam int LEN_CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
   localparam int CAP_W     = $clog2(MAX_CAPACITY + 1);
   localparam int CAP_CMP_W = (CAP_W > CFG_CAP_W) ? CAP_W : CFG_CAP_W;
   localparam int SUM_A_W   = (LEN_CMP_W > BASE_W) ? LEN_CMP_W : BASE_W;
   localparam int SUM_W     = ((SUM_A_W > CAP_CMP_W) ? SUM_A_W : CAP_CMP_W) + 1;
   localparam int SQ_W      = 2 * SAMPLE_WIDTH;
   localparam int ACC_W     = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

   eed_cfg_type cfg;

   eed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ------------------------------------------------------------------
   // Pipeline control. The output register frees when it is empty or is
   // being taken; stage one moves on whenever the output register frees,
   // and a new request enters whenever stage one is empty or moving.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic s1_fire;
   logic req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !reset && (!s1_valid_ff || out_free);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage one: the square of the sample does not depend on detector
   // state, so it is formed at the input and registered.
   // ------------------------------------------------------------------
   logic [SAMPLE_WIDTH-1:0] sample_mag;
   logic [SQ_W-1:0]         sample_sq;
   logic                    s1_restart_ff;
   logic [SQ_W-1:0]         s1_square_ff;

   always_comb begin
      if (req_sample[SAMPLE_WIDTH-1]) begin
         sample_mag = ~req_sample + 1'b1;
      end else begin
         sample_mag = req_sample;
      end
      sample_sq = sample_mag * sample_mag;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_restart_ff <= req_restart;
         s1_square_ff  <= sample_sq;
      end
   end

   // ------------------------------------------------------------------
   // Detector state.
   // ------------------------------------------------------------------
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [COUNT_W-1:0]  speech_cnt_ff, speech_cnt_in;
   logic [COUNT_W-1:0]  silence_ff, silence_in;
   logic                present_ff, present_in;
   logic [START_W-1:0]  first_ff, first_in;
   stop_code_type       stop_ff, stop_in;

   // Result of the item in stage two.
   logic done_c;
   logic speech_c;

   // Effective frame length and capacity after clamping.
   logic [LEN_CMP_W-1:0] len_ext;
   logic [LEN_CMP_W-1:0] len_eff;
   logic [CAP_CMP_W-1:0] cap_ext;
   logic [CAP_CMP_W-1:0] cap_eff;
   logic [SUM_W-1:0]     frame_end;
   logic [ACC_W-1:0]     acc_sum;
   logic [LEN_W-1:0]     pos_inc;

   always_comb begin
      len_ext = LEN_CMP_W'(cfg.frame_length);
      if (len_ext == '0) begin
         len_eff = LEN_CMP_W'(1);
      end else if (len_ext > LEN_CMP_W'(MAX_FRAME_LEN)) begin
         len_eff = LEN_CMP_W'(MAX_FRAME_LEN);
      end else begin
         len_eff = len_ext;
      end

      cap_ext = CAP_CMP_W'(cfg.capacity_samples);
      if (cap_ext > CAP_CMP_W'(MAX_CAPACITY)) begin
         cap_eff = CAP_CMP_W'(MAX_CAPACITY);
      end else begin
         cap_eff = cap_ext;
      end

      // Start from the held state, or from cleared state on a restart.
      energy_in     = energy_ff;
      pos_in        = pos_ff;
      base_in       = base_ff;
      speech_cnt_in = speech_cnt_ff;
      silence_in    = silence_ff;
      present_in    = present_ff;
      first_in      = first_ff;
      stop_in       = stop_ff;
      if (s1_restart_ff) begin
         energy_in     = '0;
         pos_in        = '0;
         base_in       = '0;
         speech_cnt_in = '0;
         silence_in    = '0;
         present_in    = 1'b0;
         first_in      = '0;
         stop_in       = STOP_RUN;
      end

      done_c   = 1'b0;
      speech_c = 1'b0;

      // A frame may start only if the whole frame still fits in capacity.
      frame_end = SUM_W'(base_in) + SUM_W'(len_eff);
      if (stop_in == STOP_RUN && pos_in == '0 && frame_end > SUM_W'(cap_eff)) begin
         stop_in = STOP_FULL;
      end

      acc_sum = ACC_W'(energy_in) + ACC_W'(s1_square_ff);
      pos_inc = pos_in + 1'b1;

      if (stop_in == STOP_RUN) begin
         if (acc_sum > ACC_W'(ENERGY_MAX)) begin
            energy_in = ENERGY_MAX;
         end else begin
            energy_in = acc_sum[ENERGY_W-1:0];
         end
         pos_in = pos_inc;
         if (LEN_CMP_W'(pos_inc) >= len_eff) begin
            done_c   = 1'b1;
            speech_c = energy_in > cfg.energy_threshold;
            if (speech_c) begin
               if (speech_cnt_in == '0) begin
                  first_in = base_in[START_W-1:0];
               end
               if (speech_cnt_in != COUNT_MAX) begin
                  speech_cnt_in = speech_cnt_in + 1'b1;
               end
               silence_in = '0;
            end else if (speech_cnt_in != '0) begin
               if (silence_in != COUNT_MAX) begin
                  silence_in = silence_in + 1'b1;
               end
            end
            if (speech_cnt_in >= cfg.min_speech_frames) begin
               present_in = 1'b1;
            end
            base_in   = frame_end[BASE_W-1:0];
            energy_in = '0;
            pos_in    = '0;
            if (present_in && silence_in >= cfg.hangover_frames) begin
               stop_in = STOP_ENDPOINT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff     <= '0;
         pos_ff        <= '0;
         base_ff       <= '0;
         speech_cnt_ff <= '0;
         silence_ff    <= '0;
         present_ff    <= 1'b0;
         first_ff      <= '0;
         stop_ff       <= STOP_RUN;
      end else if (s1_fire) begin
         energy_ff     <= energy_in;
         pos_ff        <= pos_in;
         base_ff       <= base_in;
         speech_cnt_ff <= speech_cnt_in;
         silence_ff    <= silence_in;
         present_ff    <= present_in;
         first_ff      <= first_in;
         stop_ff       <= stop_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It loads together with the state update, so a
   // finished result waits here while the next request fills stage one.
   // ------------------------------------------------------------------
   logic                rsp_done_ff;
   logic                rsp_speech_ff;
   logic                rsp_found_ff;
   logic [1:0]          rsp_status_ff;
   logic [START_W-1:0]  rsp_start_ff;
   logic [BASE_W-1:0]   rsp_taken_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_done_ff   <= done_c;
         rsp_speech_ff <= speech_c;
         rsp_found_ff  <= present_in;
         rsp_status_ff <= stop_in;
         rsp_start_ff  <= first_in;
         rsp_taken_ff  <= base_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_done    = rsp_done_ff;
   assign rsp_frame_speech  = rsp_speech_ff;
   assign rsp_speech_found  = rsp_found_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_speech_start  = rsp_start_ff;
   assign rsp_samples_taken = rsp_taken_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A speech flag only ever comes with a closed frame.
   a_speech_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_speech_ff || rsp_done_ff))
      else $error("frame_speech set without frame_done");

   // Once stopped, a sample without restart never closes a frame.
   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_restart_ff && stop_ff != STOP_RUN) |=> (rsp_valid_ff && !rsp_done_ff))
      else $error("stopped detector closed a frame");

   // The frame base only moves when a frame closes, which leaves position zero, or when a
   // restart clears it.
   a_base_moves_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(base_ff) |-> (pos_ff == '0 || $past(s1_restart_ff)))
      else $error("frame base changed mid-frame");

   // The request side stalls only when both stages are occupied.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

endmodule
